### sv/hdec_pkg.sv
`timescale 1ns / 1ps
package hdec_pkg;

   localparam int DEF_BUCKET_COUNT    = 256;
   localparam int DEF_WAYS_PER_BUCKET = 4;
   localparam int DEF_NAME_BYTES      = 24;

   localparam logic [31:0] FNV_BASIS = 32'd2166136261;
   localparam logic [31:0] FNV_PRIME = 32'd16777619;

   // Request codes.
   localparam logic [2:0] REQ_LOOKUP     = 3'd0;
   localparam logic [2:0] REQ_INSERT     = 3'd1;
   localparam logic [2:0] REQ_REMOVE     = 3'd2;
   localparam logic [2:0] REQ_INVALIDATE = 3'd3;
   localparam logic [2:0] REQ_CLEAR      = 3'd4;
   localparam logic [2:0] REQ_ENABLE     = 3'd5;

   // Result status codes.
   localparam logic [1:0] ST_DONE    = 2'd0;
   localparam logic [1:0] ST_MISS    = 2'd1;
   localparam logic [1:0] ST_FULL    = 2'd2;
   localparam logic [1:0] ST_IGNORED = 2'd3;

endpackage

### sv/hdec_store.sv
`timescale 1ns / 1ps
module hdec_store #(
   parameter int DEPTH = 1024,
   parameter int AW    = 10,
   parameter int DW    = 289
) (
   input  logic          clock,
   input  logic          wr_en,
   input  logic [AW-1:0] wr_addr,
   input  logic [DW-1:0] wr_data,
   input  logic          rd_en,
   input  logic [AW-1:0] rd_addr,
   output logic [DW-1:0] rd_data
);
   logic [DW-1:0] mem [DEPTH];
   logic [DW-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;
endmodule

### sv/hashed_directory_entry_cache.sv
`timescale 1ns / 1ps
// Lookup, insert and remove: hash rounds over the name bytes and the length, bucket modulo in the
// quotient, remainder and fix steps, a read and a compare per way, then a finishing step with the
// result strobe (disabled, or an insert of inode zero: no search). Other name bytes are taken with
// no result. Invalidate parent reads every slot and clear writes every slot, at most one store port
// access a cycle. One transaction at a time; busy stays high until its result strobe; no receiver stall.
// Reset is synchronous; after it a clearing pass over every slot keeps busy high and gives no result.
module hashed_directory_entry_cache #(
   parameter int BUCKET_COUNT    = hdec_pkg::DEF_BUCKET_COUNT,
   parameter int WAYS_PER_BUCKET = hdec_pkg::DEF_WAYS_PER_BUCKET,
   parameter int NAME_BYTES      = hdec_pkg::DEF_NAME_BYTES
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic [2:0]  req_type,
   input  logic [31:0] req_parent_inode,
   input  logic [7:0]  req_name_byte,
   input  logic        req_name_last,
   input  logic [31:0] req_inode_num,
   input  logic [31:0] req_dir_offset,
   input  logic        req_enable_value,
   output logic        rsp_valid,
   output logic [1:0]  rsp_status,
   output logic [31:0] rsp_found_inode,
   output logic [31:0] rsp_found_offset
);
   import hdec_pkg::*;

   localparam int SLOTS = BUCKET_COUNT * WAYS_PER_BUCKET;
   localparam int SW    = (SLOTS > 1) ? $clog2(SLOTS) : 1;
   localparam int BW    = (BUCKET_COUNT > 1) ? $clog2(BUCKET_COUNT) : 1;
   localparam int WCW   = $clog2(WAYS_PER_BUCKET + 1);
   localparam int LW    = $clog2(NAME_BYTES + 1);
   localparam int KIW   = (NAME_BYTES > 1) ? $clog2(NAME_BYTES) : 1;
   localparam int KW    = NAME_BYTES * 8;
   localparam int DW    = 1 + 32 + 32 + 32 + KW;
   // Reciprocal of the bucket count in 0.32 fixed point, rounded down.
   localparam logic [31:0] MOD_RECIP = 32'((64'd1 << 32) / 64'(BUCKET_COUNT));

   typedef enum logic [11:0] {
      S_IDLE    = 12'b0000_0000_0001,
      S_EXEC    = 12'b0000_0000_0010,
      S_HASH    = 12'b0000_0000_0100,
      S_QUO     = 12'b0000_0000_1000,
      S_REM     = 12'b0000_0001_0000,
      S_FIX     = 12'b0000_0010_0000,
      S_RD      = 12'b0000_0100_0000,
      S_CMP     = 12'b0000_1000_0000,
      S_ACT     = 12'b0001_0000_0000,
      S_INV_RD  = 12'b0010_0000_0000,
      S_INV_CHK = 12'b0100_0000_0000,
      S_CLR     = 12'b1000_0000_0000
   } state_type;

   state_type   state_ff, state_in;
   logic [7:0]  key_ff [NAME_BYTES];
   logic [7:0]  key_in [NAME_BYTES];
   logic [LW-1:0] count_ff, count_in, len_ff, len_in, idx_ff, idx_in;
   logic        zero_seen_ff, zero_seen_in;
   logic        enabled_ff, enabled_in;
   logic [2:0]  req_ff, req_in;
   logic [31:0] parent_ff, parent_in, ino_ff, ino_in, off_ff, off_in;
   logic        en_val_ff, en_val_in;
   logic [31:0] hash_ff, hash_in;
   logic [31:0] quo_ff, quo_in;
   logic [BW-1:0] rem_ff, rem_in;
   logic [WCW-1:0] way_ff, way_in;
   logic        hit_ff, hit_in, free_ff, free_in;
   logic [SW-1:0] hit_slot_ff, hit_slot_in, free_slot_ff, free_slot_in;
   logic [31:0] hit_ino_ff, hit_ino_in, hit_off_ff, hit_off_in;
   logic [SW-1:0] sweep_ff, sweep_in;
   logic        clr_resp_ff, clr_resp_in;
   logic        rsp_valid_ff, rsp_valid_in;
   logic [1:0]  rsp_status_ff, rsp_status_in;
   logic [31:0] rsp_ino_ff, rsp_ino_in, rsp_off_ff, rsp_off_in;

   logic          wr_en, rd_en;
   logic [SW-1:0] wr_addr, rd_addr, slot_sel;
   logic [DW-1:0] wr_data, rd_data;
   logic [KW-1:0] key_flat;
   logic [31:0]   mul_opnd, mul_coef;
   logic [63:0]   mul_prod;
   logic          rd_valid, rd_match;
   logic [31:0]   rd_parent;

   // Slot of the current way within the bucket found by the hash.
   assign slot_sel = SW'(32'(rem_ff) * WAYS_PER_BUCKET + 32'(way_ff));

   always_comb begin
      for (int i = 0; i < NAME_BYTES; i++) begin
         key_flat[i*8 +: 8] = key_ff[i];
      end
   end

   // The one shared multiplier. While hashing it runs a byte round per cycle and then the
   // length round. For the bucket it first estimates the quotient with the reciprocal, then
   // forms quotient times bucket count so that the remainder can be taken by subtraction.
   always_comb begin
      priority if (state_ff == S_QUO) begin
         mul_opnd = hash_ff;
         mul_coef = MOD_RECIP;
      end else if (state_ff == S_REM) begin
         mul_opnd = quo_ff;
         mul_coef = 32'(BUCKET_COUNT);
      end else if (idx_ff < len_ff) begin
         mul_opnd = hash_ff ^ {24'd0, key_ff[idx_ff[KIW-1:0]]};
         mul_coef = FNV_PRIME;
      end else begin
         mul_opnd = hash_ff ^ 32'(len_ff);
         mul_coef = FNV_PRIME;
      end
      mul_prod = 64'(mul_opnd) * 64'(mul_coef);
   end

   assign rd_valid  = rd_data[DW-1];
   assign rd_parent = rd_data[DW-2 -: 32];
   assign rd_match  = rd_valid && (rd_parent == parent_ff) && (rd_data[KW-1:0] == key_flat);

   always_comb begin
      state_in      = state_ff;
      key_in        = key_ff;
      count_in      = count_ff;
      len_in        = len_ff;
      idx_in        = idx_ff;
      zero_seen_in  = zero_seen_ff;
      enabled_in    = enabled_ff;
      req_in        = req_ff;
      parent_in     = parent_ff;
      ino_in        = ino_ff;
      off_in        = off_ff;
      en_val_in     = en_val_ff;
      hash_in       = hash_ff;
      quo_in        = quo_ff;
      rem_in        = rem_ff;
      way_in        = way_ff;
      hit_in        = hit_ff;
      free_in       = free_ff;
      hit_slot_in   = hit_slot_ff;
      free_slot_in  = free_slot_ff;
      hit_ino_in    = hit_ino_ff;
      hit_off_in    = hit_off_ff;
      sweep_in      = sweep_ff;
      clr_resp_in   = clr_resp_ff;
      rsp_valid_in  = 1'b0;
      rsp_status_in = rsp_status_ff;
      rsp_ino_in    = rsp_ino_ff;
      rsp_off_in    = rsp_off_ff;
      wr_en   = 1'b0;
      wr_addr = sweep_ff;
      wr_data = '0;
      rd_en   = 1'b0;
      rd_addr = sweep_ff;

      unique case (state_ff)
         S_IDLE: begin
            if (start) begin
               req_in    = req_type;
               parent_in = req_parent_inode;
               ino_in    = req_inode_num;
               off_in    = req_dir_offset;
               en_val_in = req_enable_value;
               if (req_type <= REQ_REMOVE) begin
                  // Bytes after the first zero are kept as zero, so the buffer is
                  // always in its padded form and the length is tracked on the fly.
                  if (count_ff < LW'(NAME_BYTES)) begin
                     key_in[count_ff[KIW-1:0]] = zero_seen_ff ? 8'd0 : req_name_byte;
                     count_in = count_ff + 1'b1;
                     if (!zero_seen_ff) begin
                        if (req_name_byte == 8'd0) begin
                           zero_seen_in = 1'b1;
                        end else begin
                           len_in = len_ff + 1'b1;
                        end
                     end
                  end
                  if (req_name_last) begin
                     if (!enabled_ff || (req_type == REQ_INSERT && req_inode_num == 32'd0)) begin
                        state_in = S_EXEC;
                     end else begin
                        hash_in  = FNV_BASIS ^ req_parent_inode;
                        idx_in   = '0;
                        state_in = S_HASH;
                     end
                  end
               end else begin
                  state_in = S_EXEC;
               end
            end
         end

         S_EXEC: begin
            // Requests that finish without a bucket search. Every path drops the name.
            for (int i = 0; i < NAME_BYTES; i++) key_in[i] = 8'd0;
            count_in      = '0;
            len_in        = '0;
            zero_seen_in  = 1'b0;
            rsp_ino_in    = 32'd0;
            rsp_off_in    = 32'd0;
            rsp_status_in = ST_IGNORED;
            state_in      = S_IDLE;
            priority if (req_ff == REQ_LOOKUP) begin
               rsp_status_in = ST_MISS;
               rsp_valid_in  = 1'b1;
            end else if (req_ff <= REQ_REMOVE) begin
               rsp_valid_in  = 1'b1;
            end else if (req_ff == REQ_INVALIDATE) begin
               if (enabled_ff) begin
                  sweep_in = '0;
                  state_in = S_INV_RD;
               end else begin
                  rsp_valid_in = 1'b1;
               end
            end else if (req_ff == REQ_CLEAR) begin
               rsp_status_in = ST_DONE;
               sweep_in      = '0;
               clr_resp_in   = 1'b1;
               state_in      = S_CLR;
            end else if (req_ff == REQ_ENABLE) begin
               enabled_in    = en_val_ff;
               rsp_status_in = ST_DONE;
               if (!en_val_ff || (en_val_ff != enabled_ff)) begin
                  sweep_in    = '0;
                  clr_resp_in = 1'b1;
                  state_in    = S_CLR;
               end else begin
                  rsp_valid_in = 1'b1;
               end
            end else begin
               rsp_valid_in = 1'b1;
            end
         end

         S_HASH: begin
            hash_in = mul_prod[31:0];
            if (idx_ff < len_ff) begin
               idx_in = idx_ff + 1'b1;
            end else begin
               state_in = S_QUO;
            end
         end

         S_QUO: begin
            // The estimate is never above the true quotient and at most one below it.
            quo_in   = mul_prod[63:32];
            state_in = S_REM;
         end

         S_REM: begin
            // The hash register now holds a remainder below twice the bucket count.
            hash_in  = hash_ff - mul_prod[31:0];
            state_in = S_FIX;
         end

         S_FIX: begin
            if (hash_ff >= 32'(BUCKET_COUNT)) begin
               rem_in = BW'(hash_ff - 32'(BUCKET_COUNT));
            end else begin
               rem_in = hash_ff[BW-1:0];
            end
            way_in   = '0;
            hit_in   = 1'b0;
            free_in  = 1'b0;
            state_in = S_RD;
         end

         S_RD: begin
            rd_en    = 1'b1;
            rd_addr  = slot_sel;
            state_in = S_CMP;
         end

         S_CMP: begin
            if (rd_match && !hit_ff) begin
               hit_in      = 1'b1;
               hit_slot_in = slot_sel;
               hit_ino_in  = rd_data[KW+63 -: 32];
               hit_off_in  = rd_data[KW+31 -: 32];
            end
            if (!rd_valid && !free_ff) begin
               free_in      = 1'b1;
               free_slot_in = slot_sel;
            end
            if (way_ff == WCW'(WAYS_PER_BUCKET - 1)) begin
               state_in = S_ACT;
            end else begin
               way_in   = way_ff + 1'b1;
               state_in = S_RD;
            end
         end

         S_ACT: begin
            rsp_ino_in = 32'd0;
            rsp_off_in = 32'd0;
            wr_data    = {1'b1, parent_ff, ino_ff, off_ff, key_flat};
            priority if (req_ff == REQ_LOOKUP) begin
               if (hit_ff) begin
                  rsp_status_in = ST_DONE;
                  rsp_ino_in    = hit_ino_ff;
                  rsp_off_in    = hit_off_ff;
               end else begin
                  rsp_status_in = ST_MISS;
               end
            end else if (req_ff == REQ_INSERT) begin
               if (hit_ff || free_ff) begin
                  wr_en         = 1'b1;
                  wr_addr       = hit_ff ? hit_slot_ff : free_slot_ff;
                  rsp_status_in = ST_DONE;
               end else begin
                  rsp_status_in = ST_FULL;
               end
            end else begin
               wr_data[DW-1] = 1'b0;
               wr_addr       = hit_slot_ff;
               wr_en         = hit_ff;
               rsp_status_in = hit_ff ? ST_DONE : ST_MISS;
            end
            for (int i = 0; i < NAME_BYTES; i++) key_in[i] = 8'd0;
            count_in     = '0;
            len_in       = '0;
            zero_seen_in = 1'b0;
            rsp_valid_in = 1'b1;
            state_in     = S_IDLE;
         end

         S_INV_RD: begin
            rd_en    = 1'b1;
            state_in = S_INV_CHK;
         end

         S_INV_CHK: begin
            wr_en = rd_valid && (rd_parent == parent_ff);
            if (sweep_ff == SW'(SLOTS - 1)) begin
               rsp_status_in = ST_DONE;
               rsp_ino_in    = 32'd0;
               rsp_off_in    = 32'd0;
               rsp_valid_in  = 1'b1;
               state_in      = S_IDLE;
            end else begin
               sweep_in = sweep_ff + 1'b1;
               state_in = S_INV_RD;
            end
         end

         S_CLR: begin
            wr_en = 1'b1;
            if (sweep_ff == SW'(SLOTS - 1)) begin
               rsp_ino_in   = 32'd0;
               rsp_off_in   = 32'd0;
               rsp_valid_in = clr_resp_ff;
               state_in     = S_IDLE;
            end else begin
               sweep_in = sweep_ff + 1'b1;
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLR;
         sweep_ff     <= '0;
         clr_resp_ff  <= 1'b0;
         enabled_ff   <= 1'b1;
         count_ff     <= '0;
         len_ff       <= '0;
         zero_seen_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
         for (int i = 0; i < NAME_BYTES; i++) key_ff[i] <= 8'd0;
      end else begin
         state_ff     <= state_in;
         sweep_ff     <= sweep_in;
         clr_resp_ff  <= clr_resp_in;
         enabled_ff   <= enabled_in;
         count_ff     <= count_in;
         len_ff       <= len_in;
         zero_seen_ff <= zero_seen_in;
         rsp_valid_ff <= rsp_valid_in;
         key_ff       <= key_in;
      end
   end

   always_ff @(posedge clock) begin
      idx_ff        <= idx_in;
      req_ff        <= req_in;
      parent_ff     <= parent_in;
      ino_ff        <= ino_in;
      off_ff        <= off_in;
      en_val_ff     <= en_val_in;
      hash_ff       <= hash_in;
      quo_ff        <= quo_in;
      rem_ff        <= rem_in;
      way_ff        <= way_in;
      hit_ff        <= hit_in;
      free_ff       <= free_in;
      hit_slot_ff   <= hit_slot_in;
      free_slot_ff  <= free_slot_in;
      hit_ino_ff    <= hit_ino_in;
      hit_off_ff    <= hit_off_in;
      rsp_status_ff <= rsp_status_in;
      rsp_ino_ff    <= rsp_ino_in;
      rsp_off_ff    <= rsp_off_in;
   end

   hdec_store #(
      .DEPTH (SLOTS),
      .AW    (SW),
      .DW    (DW)
   ) u_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   assign busy             = (state_ff != S_IDLE);
   assign rsp_valid        = rsp_valid_ff;
   assign rsp_status       = rsp_status_ff;
   assign rsp_found_inode  = rsp_ino_ff;
   assign rsp_found_offset = rsp_off_ff;

endmodule

### sv/hdec_checker.sv
`timescale 1ns / 1ps
module hdec_checker (
   input logic        clock,
   input logic        reset,
   input logic        start,
   input logic        busy,
   input logic [2:0]  req_type,
   input logic        rsp_valid,
   input logic [1:0]  rsp_status,
   input logic [31:0] rsp_found_inode,
   input logic [31:0] rsp_found_offset
);
   import hdec_pkg::*;

   // Every result comes from a finishing step, which always returns to idle first.
   a_no_back_to_back: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid)
      else $error("two results in consecutive cycles");

   a_found_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_status != ST_DONE) |-> (rsp_found_inode == 32'd0 &&
                                                 rsp_found_offset == 32'd0))
      else $error("found fields set on a result that is not a hit");

   a_cmd_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy && req_type > REQ_REMOVE) |=> busy)
      else $error("non-keyed transaction did not raise busy");

   a_reset_sweep: assert property (@(posedge clock)
      reset |=> busy)
      else $error("no clearing pass after reset");

endmodule

bind hashed_directory_entry_cache hdec_checker u_hdec_checker (
   .clock            (clock),
   .reset            (reset),
   .start            (start),
   .busy             (busy),
   .req_type         (req_type),
   .rsp_valid        (rsp_valid),
   .rsp_status       (rsp_status),
   .rsp_found_inode  (rsp_found_inode),
   .rsp_found_offset (rsp_found_offset)
);

### test/tb_hashed_directory_entry_cache.sv
`timescale 1ns / 1ps
module tb_hashed_directory_entry_cache;
   import hdec_pkg::*;

   localparam int BUCKETS = DEF_BUCKET_COUNT;
   localparam int WAYS    = DEF_WAYS_PER_BUCKET;
   localparam int NBYTES  = DEF_NAME_BYTES;
   localparam int SLOTS   = BUCKETS * WAYS;
   localparam logic [2:0] REQ_BAD6 = 3'd6;
   localparam logic [2:0] REQ_BAD7 = 3'd7;

   typedef logic [NBYTES*8-1:0] name_t;

   // One expected response of the cache.
   typedef struct packed {
      logic [1:0]  status;
      logic [31:0] inode;
      logic [31:0] offset;
   } answer_t;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        start = 1'b0;
   logic        busy;
   logic [2:0]  req_type = REQ_LOOKUP;
   logic [31:0] req_parent_inode = '0;
   logic [7:0]  req_name_byte = '0;
   logic        req_name_last = 1'b0;
   logic [31:0] req_inode_num = '0;
   logic [31:0] req_dir_offset = '0;
   logic        req_enable_value = 1'b0;
   logic        rsp_valid;
   logic [1:0]  rsp_status;
   logic [31:0] rsp_found_inode;
   logic [31:0] rsp_found_offset;

   hashed_directory_entry_cache DUT (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_type(req_type), .req_parent_inode(req_parent_inode),
      .req_name_byte(req_name_byte), .req_name_last(req_name_last),
      .req_inode_num(req_inode_num), .req_dir_offset(req_dir_offset),
      .req_enable_value(req_enable_value), .rsp_valid(rsp_valid),
      .rsp_status(rsp_status), .rsp_found_inode(rsp_found_inode),
      .rsp_found_offset(rsp_found_offset)
   );

   initial begin
      forever #1 clock = ~clock;
   end

   // The cache mirror: the same set-associative store that the block holds.
   logic        dir_valid  [SLOTS];
   logic [31:0] dir_parent [SLOTS];
   logic [31:0] dir_inode  [SLOTS];
   logic [31:0] dir_offset [SLOTS];
   name_t       dir_name   [SLOTS];
   logic [7:0]  pend_bytes [NBYTES];
   int          pend_count;
   logic        cache_on;

   answer_t pending_answers[$];
   int      mismatch_count = 0;
   int      orphan_count = 0;

   // A small pool of parents so that lookups and removes hit often.
   logic [31:0] parent_pool[8];

   function automatic void wipe_store();
      for (int i = 0; i < SLOTS; i++) dir_valid[i] = 1'b0;
   endfunction

   function automatic void wipe_name();
      for (int i = 0; i < NBYTES; i++) pend_bytes[i] = 8'h00;
      pend_count = 0;
   endfunction

   // Applies one accepted item to the mirror and, when it ends a request, queues its expected answer.
   function automatic void mirror_request(logic [2:0] op, logic [31:0] parent, logic [7:0] b,
                                          logic last, logic [31:0] ino, logic [31:0] off,
                                          logic en);
      answer_t     ans;
      int          len, bucket, hit, s;
      logic [31:0] h;
      name_t       key;
      ans = '{status: ST_IGNORED, inode: '0, offset: '0};
      if (op <= REQ_REMOVE) begin
         if (pend_count < NBYTES) begin
            pend_bytes[pend_count] = b;
            pend_count++;
         end
         if (!last) return;
         // The name ends at its first zero byte; everything after it reads as zero.
         len = NBYTES;
         for (int i = 0; i < NBYTES; i++)
            if (pend_bytes[i] == 8'h00) begin
               len = i;
               break;
            end
         key = '0;
         for (int i = 0; i < len; i++) key[i*8 +: 8] = pend_bytes[i];
         h = FNV_BASIS ^ parent;
         for (int i = 0; i < len; i++) h = (h ^ {24'd0, pend_bytes[i]}) * FNV_PRIME;
         h = (h ^ 32'(len)) * FNV_PRIME;
         bucket = int'(h % BUCKETS);
         hit = -1;
         for (int w = 0; w < WAYS; w++) begin
            s = bucket * WAYS + w;
            if (dir_valid[s] && dir_parent[s] == parent && dir_name[s] == key) begin
               hit = s;
               break;
            end
         end
         if (op == REQ_LOOKUP) begin
            if (cache_on && hit >= 0)
               ans = '{status: ST_DONE, inode: dir_inode[hit], offset: dir_offset[hit]};
            else
               ans.status = ST_MISS;
         end else if (!cache_on) begin
            ans.status = ST_IGNORED;
         end else if (op == REQ_INSERT) begin
            if (ino == 0) begin
               ans.status = ST_IGNORED;
            end else if (hit >= 0) begin
               dir_inode[hit] = ino;
               dir_offset[hit] = off;
               ans.status = ST_DONE;
            end else begin
               ans.status = ST_FULL;
               for (int w = 0; w < WAYS; w++) begin
                  s = bucket * WAYS + w;
                  if (!dir_valid[s]) begin
                     dir_valid[s] = 1'b1;
                     dir_parent[s] = parent;
                     dir_inode[s] = ino;
                     dir_offset[s] = off;
                     dir_name[s] = key;
                     ans.status = ST_DONE;
                     break;
                  end
               end
            end
         end else begin
            if (hit >= 0) begin
               dir_valid[hit] = 1'b0;
               ans.status = ST_DONE;
            end else begin
               ans.status = ST_MISS;
            end
         end
         wipe_name();
      end else begin
         wipe_name();
         if (op == REQ_INVALIDATE) begin
            if (cache_on) begin
               for (int i = 0; i < SLOTS; i++)
                  if (dir_valid[i] && dir_parent[i] == parent) dir_valid[i] = 1'b0;
               ans.status = ST_DONE;
            end
         end else if (op == REQ_CLEAR) begin
            wipe_store();
            ans.status = ST_DONE;
         end else if (op == REQ_ENABLE) begin
            if (!en || en != cache_on) wipe_store();
            cache_on = en;
            ans.status = ST_DONE;
         end
      end
      pending_answers.push_back(ans);
   endfunction

   // Random gap before a transaction: mostly none or short, now and then long.
   // Start drops only when a gap is taken; back to back items keep it high.
   task automatic idle_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 50) return;
      start <= 1'b0;
      if (r < 95) repeat ($urandom_range(1, 3)) @(negedge clock);
      else repeat ($urandom_range(10, 60)) @(negedge clock);
   endtask

   // Drives one item and holds it until the cache accepts it.
   task automatic send_item(logic [2:0] op, logic [31:0] parent, logic [7:0] b, logic last,
                            logic [31:0] ino, logic [31:0] off, logic en, bit gaps = 1);
      if (gaps) idle_gap();
      req_type <= op;
      req_parent_inode <= parent;
      req_name_byte <= b;
      req_name_last <= last;
      req_inode_num <= ino;
      req_dir_offset <= off;
      req_enable_value <= en;
      start <= 1'b1;
      @(posedge clock);
      while (busy) @(posedge clock);
      mirror_request(op, parent, b, last, ino, off, en);
      @(negedge clock);
   endtask

   // Sends a whole keyed request: every name byte, the last one carrying name_last.
   task automatic send_keyed(logic [2:0] op, logic [31:0] parent, logic [7:0] nm[$],
                             logic [31:0] ino, logic [31:0] off);
      logic [31:0] junk;
      for (int i = 0; i < nm.size(); i++) begin
         // Fields other than the request type and the name byte only matter on the final item.
         junk = $urandom;
         if (i == nm.size() - 1) send_item(op, parent, nm[i], 1'b1, ino, off, junk[0]);
         else send_item(op, junk, nm[i], 1'b0, $urandom, $urandom, junk[1]);
      end
   endtask

   task automatic send_simple(logic [2:0] op, logic [31:0] parent, logic en);
      send_item(op, parent, 8'($urandom), 1'($urandom), $urandom, $urandom, en);
   endtask

   function automatic void random_name(output logic [7:0] nm[$], input int maxlen);
      int n;
      nm = {};
      n = $urandom_range(1, maxlen);
      // A short alphabet so that names repeat across requests.
      for (int i = 0; i < n; i++) nm.push_back(8'h61 + 8'($urandom_range(0, 5)));
   endfunction

   // Extremes: empty names, longest and overlong names, extreme field values.
   task automatic test_directed_extremes();
      logic [7:0] nm[$];
      nm = {8'h00};
      send_keyed(REQ_INSERT, 32'hFFFF_FFFF, nm, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
      send_keyed(REQ_LOOKUP, 32'hFFFF_FFFF, nm, 0, 0);
      nm = {};
      for (int i = 0; i < NBYTES + 3; i++) nm.push_back(8'hFF - 8'(i));
      send_keyed(REQ_INSERT, 32'h0, nm, 32'h1, 32'h0);
      send_keyed(REQ_LOOKUP, 32'h0, nm, 0, 0);
      // Bytes after a zero are ignored, so this name equals "ab".
      nm = {8'h61, 8'h62, 8'h00, 8'h7A};
      send_keyed(REQ_INSERT, 32'h5, nm, 32'h55, 32'h66);
      nm = {8'h61, 8'h62, 8'h00};
      send_keyed(REQ_LOOKUP, 32'h5, nm, 0, 0);
      send_keyed(REQ_INSERT, 32'h5, nm, 32'h0, 32'h1);
      send_keyed(REQ_INSERT, 32'h5, nm, 32'h77, 32'h88);
      send_keyed(REQ_REMOVE, 32'h5, nm, 0, 0);
      send_keyed(REQ_REMOVE, 32'h5, nm, 0, 0);
   endtask

   // Inserts one name under several parents, then exercises invalidate, clear, enable and bad codes.
   task automatic test_directed_controls();
      logic [7:0] nm[$];
      nm = {8'h78};
      // Same name, different parents; the mirror decides which drop.
      for (int p = 0; p < 6; p++) send_keyed(REQ_INSERT, 32'(p) << 8, nm, 32'(p + 1), 32'(p));
      send_simple(REQ_INVALIDATE, 32'h100, 1'b0);
      send_keyed(REQ_LOOKUP, 32'h100, nm, 0, 0);
      // A partial name is discarded by a non-keyed request.
      send_item(REQ_LOOKUP, 32'h0, 8'h78, 1'b0, 0, 0, 1'b0);
      send_simple(REQ_BAD6, 32'h0, 1'b1);
      send_simple(REQ_BAD7, 32'h0, 1'b0);
      send_simple(REQ_ENABLE, 32'h0, 1'b0);
      send_keyed(REQ_INSERT, 32'h0, nm, 32'h9, 32'h9);
      send_keyed(REQ_LOOKUP, 32'h0, nm, 0, 0);
      send_simple(REQ_INVALIDATE, 32'h0, 1'b0);
      send_simple(REQ_ENABLE, 32'h0, 1'b1);
      send_simple(REQ_ENABLE, 32'h0, 1'b1);
      send_simple(REQ_CLEAR, 32'h0, 1'b0);
   endtask

   // Mostly well-formed keyed requests over a small key space, with some noise.
   task automatic test_random_traffic(int items);
      logic [7:0] nm[$];
      int         sent, r;
      logic [31:0] parent;
      sent = 0;
      while (sent < items) begin
         r = $urandom_range(0, 99);
         parent = ($urandom_range(0, 9) == 0) ? $urandom : parent_pool[$urandom_range(0, 7)];
         if (r < 92) begin
            if ($urandom_range(0, 19) == 0) random_name(nm, NBYTES + 4);
            else random_name(nm, 3);
            if ($urandom_range(0, 9) == 0) nm[$urandom_range(0, nm.size() - 1)] = 8'($urandom);
            r = $urandom_range(0, 9);
            send_keyed(r < 5 ? REQ_INSERT : (r < 8 ? REQ_LOOKUP : REQ_REMOVE), parent, nm,
                       ($urandom_range(0, 19) == 0) ? 32'h0 : $urandom, $urandom);
            sent += nm.size();
         end else begin
            r = $urandom_range(0, 9);
            if (r < 4) send_simple(REQ_INVALIDATE, parent, 1'b0);
            else if (r < 5) send_simple(REQ_CLEAR, parent, 1'b0);
            else if (r < 8) send_simple(REQ_ENABLE, parent, $urandom_range(0, 3) != 0);
            else if (r < 9) send_simple(REQ_BAD6, parent, 1'b0);
            else send_simple(REQ_BAD7, parent, 1'b1);
            sent++;
         end
      end
   endtask

   // Response checker: every strobe must match the oldest expected answer.
   always @(posedge clock) begin
      answer_t want;
      if (!reset && rsp_valid) begin
         if (pending_answers.size() == 0) begin
            orphan_count++;
            if (mismatch_count + orphan_count <= 10)
               $display("unexpected response: status %0d inode %h offset %h",
                        rsp_status, rsp_found_inode, rsp_found_offset);
         end else begin
            want = pending_answers.pop_front();
            if (rsp_status !== want.status || rsp_found_inode !== want.inode ||
                rsp_found_offset !== want.offset) begin
               mismatch_count++;
               if (mismatch_count + orphan_count <= 10)
                  $display("mismatch: expected status %0d inode %h offset %h, got %0d %h %h",
                           want.status, want.inode, want.offset,
                           rsp_status, rsp_found_inode, rsp_found_offset);
            end
         end
      end
   end

   initial begin
      for (int i = 0; i < 8; i++) parent_pool[i] = $urandom;
      parent_pool[0] = 32'h0;
      parent_pool[1] = 32'hFFFF_FFFF;
      wipe_store();
      wipe_name();
      cache_on = 1'b1;
      repeat (10) @(negedge clock);
      reset <= 1'b0;
      test_directed_extremes();
      test_directed_controls();
      test_random_traffic(960);
      start <= 1'b0;
      while (pending_answers.size() != 0) @(posedge clock);
      repeat (3 * SLOTS) @(posedge clock);
      if (mismatch_count == 0 && orphan_count == 0 && pending_answers.size() == 0)
         $display("hashed_directory_entry_cache test passed");
      else
         $display("hashed_directory_entry_cache test failed");
      $finish;
   end

   // Worst case is an invalidate walk over every slot for every item plus long gaps; this limit is
   // several times that.
   initial begin
      #30000000;
      $display("hashed_directory_entry_cache test failed");
      $finish;
   end

endmodule

### hashed_directory_entry_cache.f
sv/hdec_pkg.sv
sv/hdec_store.sv
sv/hashed_directory_entry_cache.sv
sv/hdec_checker.sv
test/tb_hashed_directory_entry_cache.sv
